### hw/rtl/in_order_release_reorder_buffer_macros.svh
// Assertion macros for the in-order release reorder buffer.
`ifndef IN_ORDER_RELEASE_REORDER_BUFFER_MACROS_SVH
`define IN_ORDER_RELEASE_REORDER_BUFFER_MACROS_SVH

// Checks a consequence in the same cycle as its antecedent.
`define IORRB_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Checks a consequence in the cycle after its antecedent.
`define IORRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/iorrb_pkg.sv
// Shared types and constants of the in-order release reorder buffer.
`default_nettype none

package iorrb_pkg;

    localparam int unsigned SEQ_W    = 16;
    localparam int unsigned HANDLE_W = 16;
    localparam int unsigned STATUS_W = 2;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_DELIVERED = 2'd0;
    localparam t_status ST_BUFFERED  = 2'd1;
    localparam t_status ST_DUPLICATE = 2'd2;

    typedef struct packed {
        logic load;
        logic eval;
        logic drain;
    } t_dp_cmd;

    typedef struct packed {
        logic more;
    } t_dp_stat;

endpackage

`default_nettype wire

### hw/rtl/in_order_release_reorder_buffer.sv
// Top level of the in-order release reorder buffer.
// A packet beat is taken when start is high and busy is low. An out-of-order, duplicate or
// zero-handle packet gives one result. A packet carrying the expected sequence number is
// delivered and then releases the run of consecutive occupied slots after it, one per cycle,
// since each further release reads its handle through the single read port of the slot
// memory. Every result appears on the result ports for exactly one cycle, flagged by
// o_result_valid, starting the cycle after the item is evaluated, and o_last marks the
// final result of each item. The receiver cannot stall the block. Slot occupancy lives in
// flip-flops cleared by reset, so the block is ready in the cycle after reset is released.
`default_nettype none

`include "in_order_release_reorder_buffer_macros.svh"

module in_order_release_reorder_buffer #(
    parameter int unsigned SLOT_COUNT = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [iorrb_pkg::SEQ_W-1:0]       i_seq_num,
    input  wire logic [iorrb_pkg::HANDLE_W-1:0]    i_payload_handle,
    output logic                                   o_result_valid,
    output logic [iorrb_pkg::STATUS_W-1:0]         o_status,
    output logic [iorrb_pkg::HANDLE_W-1:0]         o_delivered_handle,
    output logic [iorrb_pkg::SEQ_W-1:0]            o_delivered_seq,
    output logic                                   o_last
);

    iorrb_pkg::t_dp_cmd  w_cmd;
    iorrb_pkg::t_dp_stat w_stat;

    iorrb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    iorrb_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_seq_num          (i_seq_num),
        .i_payload_handle   (i_payload_handle),
        .o_result_valid     (o_result_valid),
        .o_status           (o_status),
        .o_delivered_handle (o_delivered_handle),
        .o_delivered_seq    (o_delivered_seq),
        .o_last             (o_last)
    );

    `IORRB_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "Accepted beat did not raise busy.")
    `IORRB_ASSERT_SAME(a_busy_fall_last, i_clk, i_rst_n, $fell(busy), o_result_valid && o_last, "Busy fell without a final result.")
    `IORRB_ASSERT_SAME(a_nonlast_delivered, i_clk, i_rst_n, o_result_valid && !o_last, o_status == iorrb_pkg::ST_DELIVERED, "Non-final result is not a delivery.")
    `IORRB_ASSERT_SAME(a_reject_zero, i_clk, i_rst_n, o_result_valid && (o_status != iorrb_pkg::ST_DELIVERED), (o_delivered_handle == '0) && (o_delivered_seq == '0), "Non-delivery result carries data.")

endmodule

`default_nettype wire

### hw/rtl/iorrb_ctrl.sv
// Controller state machine of the in-order release reorder buffer.
`default_nettype none

module iorrb_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire iorrb_pkg::t_dp_stat i_stat,
    output iorrb_pkg::t_dp_cmd      o_cmd,
    output logic                    o_busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DRAIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL, S_DRAIN: begin
                n_state = i_stat.more ? S_DRAIN : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_cmd.load  = i_start && (r_state == S_IDLE);
    assign o_cmd.eval  = (r_state == S_EVAL);
    assign o_cmd.drain = (r_state == S_DRAIN);
    assign o_busy      = r_busy;

endmodule

`default_nettype wire

### hw/rtl/iorrb_dp.sv
// Datapath of the in-order release reorder buffer: slot memory, occupancy and result register.
`default_nettype none

module iorrb_dp #(
    parameter int unsigned SLOT_COUNT = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire iorrb_pkg::t_dp_cmd                i_cmd,
    output iorrb_pkg::t_dp_stat                    o_stat,
    input  wire logic [iorrb_pkg::SEQ_W-1:0]       i_seq_num,
    input  wire logic [iorrb_pkg::HANDLE_W-1:0]    i_payload_handle,
    output logic                                   o_result_valid,
    output iorrb_pkg::t_status                     o_status,
    output logic [iorrb_pkg::HANDLE_W-1:0]         o_delivered_handle,
    output logic [iorrb_pkg::SEQ_W-1:0]            o_delivered_seq,
    output logic                                   o_last
);

    localparam int unsigned SW = $clog2(SLOT_COUNT);
    localparam int unsigned CW = SW + 1;
    localparam logic [SW-1:0] SLOT_MASK = SW'(SLOT_COUNT - 1);

    logic [iorrb_pkg::HANDLE_W-1:0] r_mem [SLOT_COUNT];
    logic [iorrb_pkg::HANDLE_W-1:0] r_rd_data;
    logic [SLOT_COUNT-1:0]          r_valid;
    logic [iorrb_pkg::SEQ_W-1:0]    r_exp;
    logic [iorrb_pkg::SEQ_W-1:0]    r_seq;
    logic [iorrb_pkg::HANDLE_W-1:0] r_handle;
    logic [SW-1:0]                  r_slot;

    logic                           r_out_valid;
    iorrb_pkg::t_status             r_out_status;
    logic [iorrb_pkg::HANDLE_W-1:0] r_out_handle;
    logic [iorrb_pkg::SEQ_W-1:0]    r_out_seq;
    logic                           r_out_last;

    logic [SW-1:0] w_in_raw;
    logic [SW-1:0] w_in_slot;
    logic [CW-1:0] w_inc;
    logic [SW-1:0] w_nxt;
    logic          w_match;
    logic          w_hold;
    logic          w_release;
    logic          w_buffer;
    logic          w_more;

    assign w_in_raw  = i_seq_num[SW-1:0] & SLOT_MASK;
    assign w_in_slot = ({1'b0, w_in_raw} >= CW'(SLOT_COUNT)) ? '0 : w_in_raw;
    assign w_inc     = {1'b0, r_slot} + CW'(1);
    assign w_nxt     = (w_inc == CW'(SLOT_COUNT)) ? '0 : w_inc[SW-1:0];

    assign w_match   = (r_seq == r_exp) && (r_handle != '0);
    assign w_hold    = r_valid[r_slot];
    assign w_release = (i_cmd.eval && w_match) || i_cmd.drain;
    assign w_buffer  = i_cmd.eval && (r_handle != '0) && !w_match && !w_hold;
    assign w_more    = w_release && r_valid[w_nxt];

    assign o_stat.more = w_more;

    always_ff @(posedge i_clk) begin
        if (w_buffer) begin
            r_mem[r_slot] <= r_handle;
        end
        r_rd_data <= r_mem[w_nxt];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_seq    <= i_seq_num;
            r_handle <= i_payload_handle;
            r_slot   <= w_in_slot;
        end else if (w_release) begin
            r_slot <= w_nxt;
        end
        r_out_last <= !w_more;
        if (w_release) begin
            r_out_status <= iorrb_pkg::ST_DELIVERED;
            r_out_handle <= i_cmd.drain ? r_rd_data : r_handle;
            r_out_seq    <= r_exp;
        end else begin
            r_out_status <= w_buffer ? iorrb_pkg::ST_BUFFERED : iorrb_pkg::ST_DUPLICATE;
            r_out_handle <= '0;
            r_out_seq    <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_exp       <= iorrb_pkg::SEQ_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.eval || i_cmd.drain;
            if (w_buffer) begin
                r_valid[r_slot] <= 1'b1;
            end else if (w_release) begin
                r_valid[r_slot] <= 1'b0;
            end
            if (w_release) begin
                r_exp <= r_exp + iorrb_pkg::SEQ_W'(1);
            end
        end
    end

    assign o_result_valid     = r_out_valid;
    assign o_status           = r_out_status;
    assign o_delivered_handle = r_out_handle;
    assign o_delivered_seq    = r_out_seq;
    assign o_last             = r_out_last;

endmodule

`default_nettype wire
